FILE: sv/ttf_pkg.sv
// Shared types, widths and controller-to-datapath command codes for the tangent frame block.
package ttf_pkg;

    localparam int PosW  = 32;
    localparam int TexW  = 18;
    localparam int DltW  = 19;
    localparam int EdgW  = 34;
    localparam int OpnW  = 31;
    localparam int PrdW  = 62;
    localparam int VecW  = 63;
    localparam int WrkW  = 64;
    localparam int NumW  = 47;
    localparam int LenW  = 31;
    localparam int UnitW = 16;
    localparam int IdxW  = 5;

    localparam int InDataW  = 136;
    localparam int OutDataW = 144;

    // normalization window [2^29, 2^30)
    localparam int LimLoBit = 29;
    localparam int LimHiBit = 30;

    localparam int UnitFrac = 15;
    localparam logic [UnitW-1:0] UnitMax = 16'd32767;

    // step numbers of the multiplier and the other sequenced loops
    localparam logic [IdxW-1:0] StepVecLast = 5'd19;
    localparam logic [IdxW-1:0] StepSq0     = 5'd20;
    localparam logic [IdxW-1:0] StepSqLast  = 5'd22;
    localparam logic [IdxW-1:0] RootLast    = 5'd31;
    localparam logic [IdxW-1:0] DivLast     = 5'd15;
    localparam logic [IdxW-1:0] EdgeLast    = 5'd5;
    localparam logic [IdxW-1:0] CompLast    = 5'd2;

    typedef logic signed [PosW-1:0]  t_pos;
    typedef logic signed [TexW-1:0]  t_tex;
    typedef logic signed [DltW-1:0]  t_dlt;
    typedef logic signed [EdgW-1:0]  t_edge;
    typedef logic signed [OpnW-1:0]  t_opnd;
    typedef logic signed [PrdW-1:0]  t_prod;
    typedef logic signed [VecW-1:0]  t_vec;
    typedef logic signed [WrkW-1:0]  t_wrk;
    typedef logic signed [UnitW-1:0] t_unit;

    typedef logic [3:0] t_op;

    localparam t_op OP_NOP     = 4'd0;
    localparam t_op OP_HOLD    = 4'd1;
    localparam t_op OP_EDGE    = 4'd2;
    localparam t_op OP_EMAX    = 4'd3;
    localparam t_op OP_ESHIFT  = 4'd4;
    localparam t_op OP_MUL     = 4'd5;
    localparam t_op OP_LOAD    = 4'd6;
    localparam t_op OP_WMAX    = 4'd7;
    localparam t_op OP_WSHIFT  = 4'd8;
    localparam t_op OP_RINIT   = 4'd9;
    localparam t_op OP_ROOT    = 4'd10;
    localparam t_op OP_DINIT   = 4'd11;
    localparam t_op OP_DIV     = 4'd12;
    localparam t_op OP_DSTORE  = 4'd13;
    localparam t_op OP_ZERO    = 4'd14;
    localparam t_op OP_PUBLISH = 4'd15;

    typedef struct packed {
        t_op            op;
        logic [IdxW-1:0] idx;
        logic [1:0]     vsel;
        logic           slot;
    } t_cmd;

    typedef struct packed {
        logic e_ok;
        logic w_zero;
        logic w_ok;
    } t_sts;

endpackage

FILE: sv/ttf_ctrl.sv
// Sequencer for the tangent frame block: stream handshakes, corner count and datapath steps.
module ttf_ctrl
    import ttf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EMAX  = 4'd1;
    localparam logic [3:0] S_ESCL  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_MWAIT = 4'd4;
    localparam logic [3:0] S_LOAD  = 4'd5;
    localparam logic [3:0] S_WMAX  = 4'd6;
    localparam logic [3:0] S_WSCL  = 4'd7;
    localparam logic [3:0] S_SQ    = 4'd8;
    localparam logic [3:0] S_SWAIT = 4'd9;
    localparam logic [3:0] S_RINIT = 4'd10;
    localparam logic [3:0] S_ROOT  = 4'd11;
    localparam logic [3:0] S_DINIT = 4'd12;
    localparam logic [3:0] S_DIV   = 4'd13;
    localparam logic [3:0] S_DSTO  = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0]      r_state, n_state;
    logic [IdxW-1:0] r_idx, n_idx;
    logic [1:0]      r_vsel, n_vsel;
    logic [1:0]      r_count, n_count;
    logic            r_out_valid, n_out_valid;
    logic            accept;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_vsel      = r_vsel;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        o_cmd.op    = OP_NOP;
        o_cmd.idx   = r_idx;
        o_cmd.vsel  = r_vsel;
        o_cmd.slot  = r_count[0];
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_count != 2'd2) begin
                        o_cmd.op = OP_HOLD;
                        n_count  = r_count + 2'd1;
                    end else begin
                        o_cmd.op = OP_EDGE;
                        n_count  = 2'd0;
                        n_idx    = '0;
                        n_state  = S_EMAX;
                    end
                end
            end
            S_EMAX: begin
                o_cmd.op = OP_EMAX;
                if (r_idx == EdgeLast) begin
                    n_idx   = '0;
                    n_state = S_ESCL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_ESCL: begin
                if (i_sts.e_ok) begin
                    n_idx   = '0;
                    n_state = S_MUL;
                end else begin
                    o_cmd.op = OP_ESHIFT;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                if (r_idx == StepVecLast) begin
                    n_state = S_MWAIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_MWAIT: begin
                n_vsel  = 2'd0;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_idx    = '0;
                n_state  = S_WMAX;
            end
            S_WMAX: begin
                o_cmd.op = OP_WMAX;
                if (r_idx == CompLast) begin
                    n_idx   = '0;
                    n_state = S_WSCL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_WSCL: begin
                if (i_sts.w_zero) begin
                    o_cmd.op = OP_ZERO;
                    if (r_vsel == 2'd2) begin
                        n_state = S_DONE;
                    end else begin
                        n_vsel  = r_vsel + 2'd1;
                        n_state = S_LOAD;
                    end
                end else if (i_sts.w_ok) begin
                    n_idx   = StepSq0;
                    n_state = S_SQ;
                end else begin
                    o_cmd.op = OP_WSHIFT;
                end
            end
            S_SQ: begin
                o_cmd.op = OP_MUL;
                if (r_idx == StepSqLast) begin
                    n_state = S_SWAIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SWAIT: begin
                n_state = S_RINIT;
            end
            S_RINIT: begin
                o_cmd.op = OP_RINIT;
                n_idx    = RootLast;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.op = OP_ROOT;
                if (r_idx == '0) begin
                    n_state = S_DINIT;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            S_DINIT: begin
                o_cmd.op = OP_DINIT;
                n_idx    = DivLast;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (r_idx == '0) begin
                    n_state = S_DSTO;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            S_DSTO: begin
                o_cmd.op = OP_DSTORE;
                if (r_vsel == 2'd2) begin
                    n_state = S_DONE;
                end else begin
                    n_vsel  = r_vsel + 2'd1;
                    n_state = S_LOAD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    o_cmd.op    = OP_PUBLISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_vsel      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_vsel      <= n_vsel;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: sv/ttf_dp.sv
// Datapath: held corners, edge scaling, shared multiplier, root and divide steps, result words.
module ttf_dp
    import ttf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [InDataW-1:0]  i_data,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output logic [OutDataW-1:0] o_data,
    output logic                o_degen
);

    t_pos in_pos [3];
    t_tex in_u, in_v;

    assign in_pos[0] = i_data[31:0];
    assign in_pos[1] = i_data[63:32];
    assign in_pos[2] = i_data[95:64];
    assign in_u      = i_data[113:96];
    assign in_v      = i_data[131:114];

    t_pos  r_hp [6];
    t_tex  r_ht [4];
    t_edge r_e  [6];
    t_dlt  r_d1u, r_d1v, r_d2u, r_d2v;
    logic [EdgW-2:0] r_me;

    t_prod           r_prod;
    logic [IdxW-1:0] r_pstep;
    logic            r_pv;
    t_prod           r_acc;
    logic            r_det_neg, r_det_zero;
    t_vec            r_cr [3];
    t_vec            r_tg [3];
    t_vec            r_bt [3];

    t_wrk            r_w [3];
    logic [WrkW-2:0] r_mw;
    logic [PrdW-1:0] r_sum;
    logic [WrkW-1:0] r_x, r_r;
    logic [NumW-1:0] r_num [3];
    logic [UnitW-1:0] r_q [3];

    t_unit r_res [9];
    logic  r_degen;
    logic [OutDataW-1:0] r_out;
    logic  r_out_degen;

    logic [EdgW-2:0] e_mag [6];
    logic [WrkW-2:0] w_mag [3];
    t_opnd mul_a, mul_b;
    t_vec  diff, diff_sg;
    logic [WrkW-1:0] root_bit, root_try;
    logic [LenW-1:0] len;
    logic [NumW-1:0] div_d;
    t_unit st_val [3];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            e_mag[i] = r_e[i][EdgW-1] ? (EdgW-1)'(-r_e[i]) : (EdgW-1)'(r_e[i]);
        end
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_w[i][WrkW-1] ? (WrkW-1)'(-r_w[i]) : (WrkW-1)'(r_w[i]);
        end
    end

    assign o_sts.e_ok   = (r_me == '0) ||
                          ((r_me[EdgW-2:LimHiBit] == '0) && r_me[LimLoBit]);
    assign o_sts.w_zero = (r_mw == '0);
    assign o_sts.w_ok   = (r_mw[WrkW-2:LimHiBit] == '0) && r_mw[LimLoBit];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.idx)
            5'd0:  begin mul_a = OpnW'(r_d1u); mul_b = OpnW'(r_d2v); end
            5'd1:  begin mul_a = OpnW'(r_d2u); mul_b = OpnW'(r_d1v); end
            5'd2:  begin mul_a = OpnW'(r_e[1]); mul_b = OpnW'(r_e[5]); end
            5'd3:  begin mul_a = OpnW'(r_e[2]); mul_b = OpnW'(r_e[4]); end
            5'd4:  begin mul_a = OpnW'(r_e[2]); mul_b = OpnW'(r_e[3]); end
            5'd5:  begin mul_a = OpnW'(r_e[0]); mul_b = OpnW'(r_e[5]); end
            5'd6:  begin mul_a = OpnW'(r_e[0]); mul_b = OpnW'(r_e[4]); end
            5'd7:  begin mul_a = OpnW'(r_e[1]); mul_b = OpnW'(r_e[3]); end
            5'd8:  begin mul_a = OpnW'(r_d2v); mul_b = OpnW'(r_e[0]); end
            5'd9:  begin mul_a = OpnW'(r_d1v); mul_b = OpnW'(r_e[3]); end
            5'd10: begin mul_a = OpnW'(r_d2v); mul_b = OpnW'(r_e[1]); end
            5'd11: begin mul_a = OpnW'(r_d1v); mul_b = OpnW'(r_e[4]); end
            5'd12: begin mul_a = OpnW'(r_d2v); mul_b = OpnW'(r_e[2]); end
            5'd13: begin mul_a = OpnW'(r_d1v); mul_b = OpnW'(r_e[5]); end
            5'd14: begin mul_a = OpnW'(r_d1u); mul_b = OpnW'(r_e[3]); end
            5'd15: begin mul_a = OpnW'(r_d2u); mul_b = OpnW'(r_e[0]); end
            5'd16: begin mul_a = OpnW'(r_d1u); mul_b = OpnW'(r_e[4]); end
            5'd17: begin mul_a = OpnW'(r_d2u); mul_b = OpnW'(r_e[1]); end
            5'd18: begin mul_a = OpnW'(r_d1u); mul_b = OpnW'(r_e[5]); end
            5'd19: begin mul_a = OpnW'(r_d2u); mul_b = OpnW'(r_e[2]); end
            5'd20: begin mul_a = OpnW'(r_w[0]); mul_b = OpnW'(r_w[0]); end
            5'd21: begin mul_a = OpnW'(r_w[1]); mul_b = OpnW'(r_w[1]); end
            5'd22: begin mul_a = OpnW'(r_w[2]); mul_b = OpnW'(r_w[2]); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign diff     = VecW'(r_acc) - VecW'(r_prod);
    assign diff_sg  = r_det_neg ? -diff : diff;
    assign root_bit = WrkW'(1) << {i_cmd.idx, 1'b0};
    assign root_try = r_r + root_bit;
    assign len      = r_r[LenW-1:0];
    assign div_d    = NumW'(len) << i_cmd.idx[3:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            st_val[i] = r_q[i][UnitW-1] ? t_unit'(UnitMax) : t_unit'(r_q[i]);
            if (r_w[i][WrkW-1]) begin
                st_val[i] = -st_val[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_hp[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_ht[i] <= '0;
            end
            r_pv <= 1'b0;
        end else begin
            r_pv <= (i_cmd.op == OP_MUL);
            if (i_cmd.op == OP_HOLD) begin
                if (i_cmd.slot) begin
                    for (int i = 0; i < 3; i++) begin
                        r_hp[3+i] <= in_pos[i];
                    end
                    r_ht[2] <= in_u;
                    r_ht[3] <= in_v;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        r_hp[i] <= in_pos[i];
                    end
                    r_ht[0] <= in_u;
                    r_ht[1] <= in_v;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= mul_a * mul_b;
        r_pstep <= i_cmd.idx;
        if (r_pv) begin
            if (r_pstep >= StepSq0) begin
                r_sum <= r_sum + PrdW'(r_prod);
            end else if (!r_pstep[0]) begin
                r_acc <= r_prod;
            end else begin
                case (r_pstep[4:1])
                    4'd0: begin
                        r_det_zero <= (diff == '0);
                        r_det_neg  <= diff[VecW-1];
                    end
                    4'd1: r_cr[0] <= diff;
                    4'd2: r_cr[1] <= diff;
                    4'd3: r_cr[2] <= diff;
                    4'd4: r_tg[0] <= diff_sg;
                    4'd5: r_tg[1] <= diff_sg;
                    4'd6: r_tg[2] <= diff_sg;
                    4'd7: r_bt[0] <= diff_sg;
                    4'd8: r_bt[1] <= diff_sg;
                    4'd9: r_bt[2] <= diff_sg;
                    default: ;
                endcase
            end
        end

        unique case (i_cmd.op)
            OP_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    r_e[i]   <= EdgW'(r_hp[3+i]) - EdgW'(r_hp[i]);
                    r_e[3+i] <= EdgW'(in_pos[i]) - EdgW'(r_hp[i]);
                end
                r_d1u   <= DltW'(r_ht[2]) - DltW'(r_ht[0]);
                r_d1v   <= DltW'(r_ht[3]) - DltW'(r_ht[1]);
                r_d2u   <= DltW'(in_u) - DltW'(r_ht[0]);
                r_d2v   <= DltW'(in_v) - DltW'(r_ht[1]);
                r_me    <= '0;
                r_degen <= 1'b0;
            end
            OP_EMAX: begin
                if (e_mag[i_cmd.idx[2:0]] > r_me) begin
                    r_me <= e_mag[i_cmd.idx[2:0]];
                end
            end
            OP_ESHIFT: begin
                if (r_me[EdgW-2:LimHiBit] != '0) begin
                    for (int i = 0; i < 6; i++) begin
                        r_e[i] <= r_e[i] >>> 1;
                    end
                    r_me <= r_me >> 1;
                end else begin
                    for (int i = 0; i < 6; i++) begin
                        r_e[i] <= r_e[i] <<< 1;
                    end
                    r_me <= r_me << 1;
                end
            end
            OP_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    case (i_cmd.vsel)
                        2'd0:    r_w[i] <= WrkW'(r_cr[i]);
                        2'd1:    r_w[i] <= r_det_zero ? '0 : WrkW'(r_tg[i]);
                        default: r_w[i] <= r_det_zero ? '0 : WrkW'(r_bt[i]);
                    endcase
                end
                r_mw  <= '0;
                r_sum <= '0;
            end
            OP_WMAX: begin
                if (w_mag[i_cmd.idx[1:0]] > r_mw) begin
                    r_mw <= w_mag[i_cmd.idx[1:0]];
                end
            end
            OP_WSHIFT: begin
                if (r_mw[WrkW-2:LimHiBit] != '0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_w[i] <= r_w[i] >>> 1;
                    end
                    r_mw <= r_mw >> 1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        r_w[i] <= r_w[i] <<< 1;
                    end
                    r_mw <= r_mw << 1;
                end
            end
            OP_RINIT: begin
                r_x <= WrkW'(r_sum);
                r_r <= '0;
            end
            OP_ROOT: begin
                if (r_x >= root_try) begin
                    r_x <= r_x - root_try;
                    r_r <= (r_r >> 1) + root_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
            end
            OP_DINIT: begin
                // a negative component shifted down can reach magnitude 2^30
                for (int i = 0; i < 3; i++) begin
                    r_num[i] <= NumW'({w_mag[i][LimHiBit:0], {UnitFrac{1'b0}}}) +
                                NumW'(len >> 1);
                    r_q[i]   <= '0;
                end
            end
            OP_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_num[i] >= div_d) begin
                        r_num[i]            <= r_num[i] - div_d;
                        r_q[i][i_cmd.idx[3:0]] <= 1'b1;
                    end
                end
            end
            OP_DSTORE: begin
                for (int i = 0; i < 3; i++) begin
                    case (i_cmd.vsel)
                        2'd0:    r_res[i]   <= st_val[i];
                        2'd1:    r_res[3+i] <= st_val[i];
                        default: r_res[6+i] <= st_val[i];
                    endcase
                end
            end
            OP_ZERO: begin
                for (int i = 0; i < 3; i++) begin
                    case (i_cmd.vsel)
                        2'd0:    r_res[i]   <= '0;
                        2'd1:    r_res[3+i] <= '0;
                        default: r_res[6+i] <= '0;
                    endcase
                end
                r_degen <= 1'b1;
            end
            OP_PUBLISH: begin
                for (int i = 0; i < 9; i++) begin
                    r_out[i*UnitW +: UnitW] <= r_res[i];
                end
                r_out_degen <= r_degen;
            end
            default: ;
        endcase
    end

    assign o_data  = r_out;
    assign o_degen = r_out_degen;

endmodule

FILE: sv/triangle_tangent_frame.sv
// Top level of the per-face normal, tangent and bitangent generator.
// Corners stream in one word each; the first two of a triangle are only held and may be
// accepted while the previous result still waits on the output. The third corner starts a
// sequenced computation on one shared 31x31 multiplier: an edge magnitude search, edge shifts
// into the normalization window and the determinant, normal, tangent and bitangent products,
// then for each of normal, tangent and bitangent a magnitude search, shifts, the squares, a
// 32-step square root and a 16-step divide run on all three components at once; a zero-length
// vector gets a zero result and sets the degenerate flag instead.
module triangle_tangent_frame
    import ttf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], tex_u[113:96], tex_v[131:114], zero pad
    input  logic [InDataW-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // normal_x/y/z[47:0], tangent_x/y/z[95:48], bitangent_x/y/z[143:96], 16 bits each
    output logic [OutDataW-1:0] m_axis_tdata,
    // degenerate[0]
    output logic                m_axis_tuser
);

    t_cmd cmd;
    t_sts sts;

    ttf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    ttf_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (s_axis_tdata),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_data  (m_axis_tdata),
        .o_degen (m_axis_tuser)
    );

endmodule

FILE: sv/ttf_checker.sv
// Port-level checks for the tangent frame block, bound to the top level.
module ttf_checker
    import ttf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata,
    input logic                m_axis_tuser
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hs_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(s_axis_tready) && !$isunknown(m_axis_tvalid))
        else $error("handshake output unknown");

    a_unit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            (m_axis_tdata[47:0] != '0) && (m_axis_tdata[95:48] != '0) &&
            (m_axis_tdata[143:96] != '0))
        else $error("zero vector without degenerate flag");

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb_triangle_tangent_frame.sv
// Self-checking testbench for triangle_tangent_frame: corner stream in, face frames checked out.
module tb_triangle_tangent_frame
    import ttf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] nx, ny, nz, tx, ty, tz, bx, by, bz;
        logic               degen;
    } t_frame;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    triangle_tangent_frame dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // held corner state of the predictor
    longint held_p[6];
    longint held_t[4];
    int     corners;

    logic [InDataW-1:0] corner_q[$];
    t_frame             frame_q[$];
    int  errors = 0;
    int  frames_seen = 0;
    int  degen_seen = 0;
    int  send_idle = 0;
    int  recv_stall = 0;
    bit  hold_go = 0;
    bit  hold_on = 0;
    longint cycles = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    function automatic longint sx(logic [63:0] v, int w);
        logic [63:0] m;
        m = (64'd1 << w) - 1;
        v = v & m;
        if (v[w-1]) return longint'(v) - (longint'(1) << w);
        return longint'(v);
    endfunction

    function automatic longint fl_shr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint absv(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic bit window_shift(ref longint v[6], input int n);
        longint m;
        int k;
        m = 0;
        k = 0;
        for (int i = 0; i < n; i++) if (absv(v[i]) > m) m = absv(v[i]);
        if (m == 0) return 0;
        if (m >= (longint'(1) << 30)) begin
            while ((m >> k) >= (longint'(1) << 30)) k++;
            for (int i = 0; i < n; i++) v[i] = fl_shr(v[i], k);
        end else begin
            while ((m << k) < (longint'(1) << 29)) k++;
            for (int i = 0; i < n; i++) v[i] = v[i] << k;
        end
        return 1;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // unit vector in Q1.15; returns 0 on zero length
    function automatic bit unit_vec(longint c0, longint c1, longint c2,
                                    output logic signed [31:0] o0, o1, o2);
        longint v[6];
        longint unsigned sum, len, q;
        logic signed [31:0] o[3];
        v = '{c0, c1, c2, 0, 0, 0};
        sum = 0;
        if (!window_shift(v, 3)) begin
            o0 = 0; o1 = 0; o2 = 0;
            return 0;
        end
        for (int i = 0; i < 3; i++) sum += longint'(v[i] * v[i]);
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((longint'(absv(v[i])) << 15) + (len >> 1)) / len;
            if (q > 32767) q = 32767;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        o0 = o[0]; o1 = o[1]; o2 = o[2];
        return 1;
    endfunction

    task automatic predict_frame(logic [InDataW-1:0] w);
        longint px, py, pz, tu, tv, d1u, d1v, d2u, d2v, det, sg;
        longint e[6];
        t_frame f;
        px = sx(w[31:0], 32);
        py = sx(w[63:32], 32);
        pz = sx(w[95:64], 32);
        tu = sx(w[113:96], 18);
        tv = sx(w[131:114], 18);
        if (corners < 2) begin
            held_p[corners*3] = px; held_p[corners*3+1] = py; held_p[corners*3+2] = pz;
            held_t[corners*2] = tu; held_t[corners*2+1] = tv;
            corners++;
            return;
        end
        corners = 0;
        for (int i = 0; i < 3; i++) e[i] = held_p[3+i] - held_p[i];
        e[3] = px - held_p[0];
        e[4] = py - held_p[1];
        e[5] = pz - held_p[2];
        void'(window_shift(e, 6));
        d1u = held_t[2] - held_t[0];
        d1v = held_t[3] - held_t[1];
        d2u = tu - held_t[0];
        d2v = tv - held_t[1];
        det = d1u * d2v - d2u * d1v;
        f.degen = 0;
        if (!unit_vec(e[1]*e[5] - e[2]*e[4], e[2]*e[3] - e[0]*e[5], e[0]*e[4] - e[1]*e[3],
                      f.nx, f.ny, f.nz))
            f.degen = 1;
        if (det == 0) begin
            f.degen = 1;
            f.tx = 0; f.ty = 0; f.tz = 0; f.bx = 0; f.by = 0; f.bz = 0;
        end else begin
            sg = det < 0 ? -1 : 1;
            if (!unit_vec(sg*(d2v*e[0] - d1v*e[3]), sg*(d2v*e[1] - d1v*e[4]),
                          sg*(d2v*e[2] - d1v*e[5]), f.tx, f.ty, f.tz))
                f.degen = 1;
            if (!unit_vec(sg*(d1u*e[3] - d2u*e[0]), sg*(d1u*e[4] - d2u*e[1]),
                          sg*(d1u*e[5] - d2u*e[2]), f.bx, f.by, f.bz))
                f.degen = 1;
        end
        frame_q = {frame_q, f};
    endtask

    function automatic logic [InDataW-1:0] pack_corner(logic [31:0] x, y, z,
                                                       logic [17:0] u, v);
        return {4'd0, v, u, z, y, x};
    endfunction

    function automatic logic [31:0] rnd_pos();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 2000)) - 1000);
            2: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            default: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [17:0] rnd_tex();
        case ($urandom_range(0, 3))
            0: return 18'($urandom);
            1: return 18'(int'($urandom_range(0, 64)) - 32);
            default: return 18'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_frame(s_axis_tdata);
                void'(corner_q.pop_front());
            end
            if ((!s_axis_tvalid || s_axis_tready)) begin
                if (corner_q.size() > 0 && !($urandom_range(0, 99) < send_idle)) begin
                    s_axis_tvalid <= 1;
                    s_axis_tdata  <= corner_q[0];
                end else begin
                    s_axis_tvalid <= 0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1;
        repeat (3000) @(posedge i_clk);
        hold_on <= 0;
    end

    // monitor / checker
    always @(posedge i_clk) begin
        t_frame f, a;
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                a.nx = $signed(m_axis_tdata[15:0]);    a.ny = $signed(m_axis_tdata[31:16]);
                a.nz = $signed(m_axis_tdata[47:32]);   a.tx = $signed(m_axis_tdata[63:48]);
                a.ty = $signed(m_axis_tdata[79:64]);   a.tz = $signed(m_axis_tdata[95:80]);
                a.bx = $signed(m_axis_tdata[111:96]);  a.by = $signed(m_axis_tdata[127:112]);
                a.bz = $signed(m_axis_tdata[143:128]); a.degen = m_axis_tuser;
                frames_seen++;
                if (a.degen) degen_seen++;
                if (frame_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected frame %p", $realtime, a);
                end else begin
                    f = frame_q.pop_front();
                    if (f !== a) begin
                        errors++;
                        $display("%0t mismatch expected %p actual %p", $realtime, f, a);
                    end
                end
            end
            if (hold_on) begin
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= !($urandom_range(0, 99) < recv_stall);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3_000_000) begin
            $display("[triangle_tangent_frame] ERROR");
            $finish;
        end
    end

    task automatic add_tri(logic [31:0] x0, y0, z0, x1, y1, z1, x2, y2, z2,
                           logic [17:0] u0, v0, u1, v1, u2, v2);
        corner_q = {corner_q, pack_corner(x0, y0, z0, u0, v0)};
        corner_q = {corner_q, pack_corner(x1, y1, z1, u1, v1)};
        corner_q = {corner_q, pack_corner(x2, y2, z2, u2, v2)};
    endtask

    task automatic drain();
        wait (corner_q.size() == 0 && !s_axis_tvalid);
        wait (frame_q.size() == 0);
    endtask

    task automatic random_tris(int n);
        for (int i = 0; i < n; i++)
            add_tri(rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(),
                    rnd_pos(), rnd_pos(), rnd_pos(), rnd_tex(), rnd_tex(), rnd_tex(),
                    rnd_tex(), rnd_tex(), rnd_tex());
    endtask

    initial begin
        corners = 0;
        foreach (held_p[i]) held_p[i] = 0;
        foreach (held_t[i]) held_t[i] = 0;
        i_rst_n = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: unit triangle, coincident corners, zero det, collinear corners, extremes
        add_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0,
                0, 0, 18'h10000, 0, 0, 18'h10000);
        add_tri(5, 5, 5, 5, 5, 5, 5, 5, 5, 1, 2, 3, 4, 5, 7);
        add_tri(0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000, 7, 7, 7, 7, 7, 7);
        add_tri(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                18'h20000, 18'h1ffff, 18'h1ffff, 18'h20000, 18'h20000, 18'h20000);
        add_tri(0, 0, 0, 1, 0, 0, 2, 0, 0, 0, 0, 1, 0, 0, 1);
        add_tri(32'hffff_ffff, 0, 0, 0, 32'hffff_ffff, 0, 0, 0, 32'hffff_ffff,
                18'h3ffff, 0, 0, 18'h3ffff, 18'h3ffff, 18'h3ffff);
        add_tri(0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 18'h20000, 0, 0, 18'h1ffff);
        add_tri(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 1);
        drain();

        random_tris(60);
        drain();
        send_idle = 87;
        random_tris(50);
        drain();
        send_idle = 0;
        recv_stall = 87;
        random_tris(50);
        drain();
        recv_stall = 0;
        hold_go = 1;
        random_tris(20);
        drain();
        send_idle = 17;
        recv_stall = 17;
        random_tris(50);
        drain();
        repeat (400) @(posedge i_clk);

        $display("checked %0d face frames (%0d degenerate) from %0d-ish corners",
                 frames_seen, degen_seen, 3 * (8 + 230));
        $display("idle phases: none, sender, receiver, long hold-off, both");
        if (errors == 0 && frame_q.size() == 0)
            $display("[triangle_tangent_frame] OK");
        else
            $display("[triangle_tangent_frame] ERROR");
        $finish;
    end
endmodule

FILE: triangle_tangent_frame.f
sv/ttf_pkg.sv
sv/ttf_ctrl.sv
sv/ttf_dp.sv
sv/triangle_tangent_frame.sv
sv/ttf_checker.sv
tb/sv/tb_triangle_tangent_frame.sv
